// File: src/cdconv_pkg.sv
// Shared widths, constants and small tables of the civil date converter.
// Used by the channel interfaces, both datapaths and the top level.
// No dependencies.
package cdconv_pkg;

  // Field widths of the channel words.
  localparam int OffsetW = 25;
  localparam int YearW   = 16;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;

  // Action codes.
  localparam logic ActToDate = 1'b0;
  localparam logic ActToDays = 1'b1;

  // Reset value of the epoch register: 2026-01-01.
  localparam int EpochReset = 20454;

  // Calendar constants of the era / year-of-era method.
  localparam int DaysTo1970  = 719468;
  localparam int DaysPerEra  = 146097;
  localparam int DaysPerYear = 365;
  localparam int YearsPerEra = 400;

  // Pipeline depth in front of the output register.
  localparam int NumStages = 12;
  typedef logic [NumStages:1] stage_en_t;

  // Day number to date: the day count is biased by whole eras so that it is
  // never negative, then divided by reciprocal multiplication.
  localparam int EraBiasA  = 256;
  localparam int ZbW       = 27;
  localparam int ZbBias    = DaysTo1970 + EraBiasA * DaysPerEra;
  localparam int RecipEra  = (1 << ZbW) / DaysPerEra;
  localparam int RecipEraW = 10;
  localparam int EraW      = 9;
  localparam int RemEraW   = 19;
  localparam int DoeW      = 18;
  localparam int Recip1460 = (1 << DoeW) / 1460;
  localparam int Recip365  = (1 << DoeW) / DaysPerYear;
  localparam int YoeW      = 9;
  localparam int DoyW      = 9;
  localparam int YearFullW = 19;

  // Date to day number: the year is biased by whole eras in the same way.
  localparam int EraBiasB  = 128;
  localparam int YbW       = 17;
  localparam int YearBiasB = EraBiasB * YearsPerEra;
  localparam int Recip400  = (1 << YbW) / YearsPerEra;
  localparam int IntW      = 28;

  // First day of each month of the March-based year; entry 12 lies past
  // the end of the year and is reached only by month code 15.
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] mp);
    logic [DoyW-1:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      4'd12:   start = 9'd367;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

  // Days from the start of the era to the start of year yoe (0..399).
  function automatic logic [DoeW-1:0] days_before_year(input logic [YoeW-1:0] yoe);
    logic [1:0] cent;
    cent = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    return DoeW'(yoe) * DoeW'(DaysPerYear) + DoeW'(yoe >> 2) - DoeW'(cent);
  endfunction

endpackage

// File: src/cdconv_ifs.sv
// Valid/ready channel interfaces of the civil date converter.
// Depends on cdconv_pkg for the field widths.
interface cdconv_in_if import cdconv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [OffsetW-1:0] day_offset;
  logic signed [YearW-1:0]   year_in;
  logic [MonthW-1:0]         month_in;
  logic [DayW-1:0]           day_in;

  modport source (output valid, action, day_offset, year_in, month_in, day_in,
                  input ready);
  modport sink   (input valid, action, day_offset, year_in, month_in, day_in,
                  output ready);
endinterface

interface cdconv_out_if import cdconv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [YearW-1:0]   year_out;
  logic [MonthW-1:0]         month_out;
  logic [DayW-1:0]           day_out;
  logic signed [OffsetW-1:0] offset_out;
  logic                      range_error;

  modport source (output valid, year_out, month_out, day_out, offset_out, range_error,
                  input ready);
  modport sink   (input valid, year_out, month_out, day_out, offset_out, range_error,
                  output ready);
endinterface

// File: src/cdconv_days2date.sv
// Twelve-stage datapath that turns a day offset from the epoch into a civil date.
// Depends on cdconv_pkg; stage loads come from the top level's valid chain.
module cdconv_days2date import cdconv_pkg::*; (
  input  logic                      clk_i,
  input  stage_en_t                 en_i,
  input  logic signed [OffsetW-1:0] epoch_i,
  input  logic signed [OffsetW-1:0] day_offset_i,
  output logic signed [YearW-1:0]   year_o,
  output logic [MonthW-1:0]         month_o,
  output logic [DayW-1:0]           day_o,
  output logic                      err_o
);

  // Stage registers.
  logic [ZbW-1:0]                zb1_q, zb2_q;
  logic [EraW-1:0]               qe2_q, qe3_q, era4_q;
  logic [RemEraW-1:0]            r3_q;
  logic [DoeW-1:0]               doe4_q, doe5_q, doe6_q, doe7_q, doe8_q, doe9_q, doe10_q;
  logic [6:0]                    q1460e5_q, q1460e6_q;
  logic [1:0]                    k5_q, k6_q;
  logic [11:0]                   r1460_6_q;
  logic [DoeW-1:0]               n7_q, n8_q;
  logic [YoeW-1:0]               ye8_q, ye9_q, yoe10_q, yoe11_q, yoe12_q;
  logic [9:0]                    r365_9_q;
  logic [DoyW-1:0]               doy11_q, doy12_q;
  logic [MonthW-1:0]             mp12_q;
  logic signed [YearFullW-1:0]   eray5_q, eray6_q, eray7_q, eray8_q, eray9_q, eray10_q;
  logic signed [YearFullW-1:0]   eray11_q, eray12_q;

  // Next values.
  logic [ZbW-1:0]                zb1_d;
  logic [ZbW+RecipEraW-1:0]      era_prod;
  logic [EraW-1:0]               qe2_d;
  logic [ZbW-1:0]                rem_era;
  logic                          era_ge;
  logic [DoeW-1:0]               doe4_d;
  logic [EraW-1:0]               era4_d;
  logic [DoeW+7:0]               prod1460;
  logic [2:0]                    c36524;
  logic [1:0]                    k5_d;
  logic signed [YearFullW-1:0]   era_s, eray5_d;
  logic [DoeW-1:0]               rem1460;
  logic [6:0]                    q1460;
  logic [DoeW-1:0]               n7_d;
  logic [DoeW+9:0]               prod365;
  logic [DoeW-1:0]               rem365;
  logic [YoeW-1:0]               yoe10_d;
  logic [DoeW-1:0]               doy_full;
  logic [MonthW-1:0]             mp_d;
  logic [DoyW-1:0]               day_full;
  logic                          early;
  logic signed [YearFullW-1:0]   year_full;

  always_comb begin
    zb1_d = {{(ZbW-OffsetW){epoch_i[OffsetW-1]}}, epoch_i}
          + {{(ZbW-OffsetW){day_offset_i[OffsetW-1]}}, day_offset_i}
          + ZbW'(ZbBias);

    // The reciprocal estimate is low by at most one; stage 4 corrects it.
    era_prod = (ZbW+RecipEraW)'(zb1_q) * (ZbW+RecipEraW)'(RecipEra);
    qe2_d    = era_prod[ZbW+EraW-1:ZbW];

    rem_era = zb2_q - ZbW'(qe2_q) * ZbW'(DaysPerEra);

    era_ge = (r3_q >= RemEraW'(DaysPerEra));
    doe4_d = era_ge ? DoeW'(r3_q - RemEraW'(DaysPerEra)) : DoeW'(r3_q);
    era4_d = qe3_q + EraW'(era_ge);

    prod1460 = (DoeW+8)'(doe4_q) * (DoeW+8)'(Recip1460);
    c36524   = 3'(doe4_q >= 18'd36524) + 3'(doe4_q >= 18'd73048)
             + 3'(doe4_q >= 18'd109572) + 3'(doe4_q >= 18'd146096);
    // doe never exceeds 146096, so doe/146096 is one only at that value.
    k5_d     = 2'(c36524 - 3'(doe4_q == 18'd146096));
    era_s    = YearFullW'(era4_q) - YearFullW'(EraBiasA);
    eray5_d  = era_s * YearFullW'(YearsPerEra);

    rem1460 = doe5_q - DoeW'(q1460e5_q) * DoeW'(1460);

    q1460 = q1460e6_q + 7'(r1460_6_q >= 12'd1460);
    n7_d  = doe6_q - DoeW'(q1460) + DoeW'(k6_q);

    prod365 = (DoeW+10)'(n7_q) * (DoeW+10)'(Recip365);

    rem365 = n8_q - DoeW'(ye8_q) * DoeW'(DaysPerYear);

    yoe10_d = ye9_q + YoeW'(r365_9_q >= 10'd365);

    doy_full = doe10_q - days_before_year(yoe10_q);

    mp_d = '0;
    for (int i = 1; i <= 11; i++) begin
      mp_d = mp_d + MonthW'(doy11_q >= month_start(MonthW'(i)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      zb1_q <= zb1_d;
    end
    if (en_i[2]) begin
      zb2_q <= zb1_q;
      qe2_q <= qe2_d;
    end
    if (en_i[3]) begin
      r3_q  <= rem_era[RemEraW-1:0];
      qe3_q <= qe2_q;
    end
    if (en_i[4]) begin
      doe4_q <= doe4_d;
      era4_q <= era4_d;
    end
    if (en_i[5]) begin
      doe5_q    <= doe4_q;
      q1460e5_q <= prod1460[DoeW+6:DoeW];
      k5_q      <= k5_d;
      eray5_q   <= eray5_d;
    end
    if (en_i[6]) begin
      doe6_q    <= doe5_q;
      q1460e6_q <= q1460e5_q;
      r1460_6_q <= rem1460[11:0];
      k6_q      <= k5_q;
      eray6_q   <= eray5_q;
    end
    if (en_i[7]) begin
      doe7_q  <= doe6_q;
      n7_q    <= n7_d;
      eray7_q <= eray6_q;
    end
    if (en_i[8]) begin
      doe8_q  <= doe7_q;
      n8_q    <= n7_q;
      ye8_q   <= prod365[DoeW+YoeW-1:DoeW];
      eray8_q <= eray7_q;
    end
    if (en_i[9]) begin
      doe9_q   <= doe8_q;
      ye9_q    <= ye8_q;
      r365_9_q <= rem365[9:0];
      eray9_q  <= eray8_q;
    end
    if (en_i[10]) begin
      doe10_q  <= doe9_q;
      yoe10_q  <= yoe10_d;
      eray10_q <= eray9_q;
    end
    if (en_i[11]) begin
      doy11_q  <= doy_full[DoyW-1:0];
      yoe11_q  <= yoe10_q;
      eray11_q <= eray10_q;
    end
    if (en_i[12]) begin
      doy12_q  <= doy11_q;
      mp12_q   <= mp_d;
      yoe12_q  <= yoe11_q;
      eray12_q <= eray11_q;
    end
  end

  // Final step, registered in the top level's output register.
  always_comb begin
    day_full  = doy12_q - month_start(mp12_q) + 9'd1;
    early     = (mp12_q >= 4'd10);
    year_full = eray12_q + YearFullW'(yoe12_q) + YearFullW'(early);
    day_o     = day_full[DayW-1:0];
    month_o   = early ? mp12_q - 4'd9 : mp12_q + 4'd3;
    year_o    = year_full[YearW-1:0];
    err_o     = (year_full < -32768) || (year_full > 32767);
  end

endmodule

// File: src/cdconv_date2days.sv
// Datapath that turns a civil date into a day offset from the epoch; the result
// is ready after seven stages and rides along to stage twelve. Depends on cdconv_pkg.
module cdconv_date2days import cdconv_pkg::*; (
  input  logic                      clk_i,
  input  stage_en_t                 en_i,
  input  logic signed [OffsetW-1:0] epoch_i,
  input  logic signed [YearW-1:0]   year_i,
  input  logic [MonthW-1:0]         month_i,
  input  logic [DayW-1:0]           day_i,
  output logic signed [OffsetW-1:0] offset_o,
  output logic                      err_o
);

  localparam int DoneStage = 7;

  logic [YbW-1:0]              yb1_q, yb2_q;
  logic [MonthW-1:0]           mterm1_q;
  logic [DayW-1:0]             day1_q;
  logic [7:0]                  qy2_q, qy3_q, erab4_q;
  logic signed [9:0]           doy2_q, doy3_q, doy4_q, doy5_q;
  logic [9:0]                  ry3_q;
  logic [YoeW-1:0]             yoe4_q;
  logic [DoeW-1:0]             pday5_q;
  logic signed [IntW-1:0]      eraprod5_q, kofs5_q, doe6_q, base6_q;
  logic [OffsetW-1:0]          offc_q [DoneStage:NumStages];
  logic                        errc_q [DoneStage:NumStages];

  logic                        early;
  logic [YbW-1:0]              yb1_d;
  logic [MonthW-1:0]           mterm1_d;
  logic [YbW+8:0]              prod400;
  logic signed [9:0]           doy2_d;
  logic [YbW-1:0]              rem400;
  logic                        yr_ge;
  logic [9:0]                  yoe_wide;
  logic signed [8:0]           era_s;
  logic signed [IntW-1:0]      era_ext, eraprod_d, kofs_d, doe_d, base_d, off_d;
  logic                        err_d;

  always_comb begin
    // January and February count as the end of the previous March-based year.
    early    = (month_i <= 4'd2);
    yb1_d    = {year_i[YearW-1], year_i} + YbW'(YearBiasB) - YbW'(early);
    mterm1_d = early ? month_i + 4'd9 : month_i - 4'd3;

    prod400 = (YbW+9)'(yb1_q) * (YbW+9)'(Recip400);
    doy2_d  = 10'(month_start(mterm1_q)) + 10'(day1_q) - 10'd1;

    rem400 = yb2_q - YbW'(qy2_q) * YbW'(YearsPerEra);

    yr_ge    = (ry3_q >= 10'd400);
    yoe_wide = yr_ge ? ry3_q - 10'd400 : ry3_q;

    era_s     = 9'(erab4_q) - 9'(EraBiasB);
    era_ext   = {{(IntW-9){era_s[8]}}, era_s};
    eraprod_d = era_ext * IntW'(DaysPerEra);
    kofs_d    = {{(IntW-OffsetW){epoch_i[OffsetW-1]}}, epoch_i} + IntW'(DaysTo1970);

    doe_d  = IntW'(pday5_q) + {{(IntW-10){doy5_q[9]}}, doy5_q};
    base_d = eraprod5_q - kofs5_q;

    off_d = base6_q + doe6_q;
    err_d = (off_d < -(1 << (OffsetW-1))) || (off_d > (1 << (OffsetW-1)) - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      yb1_q    <= yb1_d;
      mterm1_q <= mterm1_d;
      day1_q   <= day_i;
    end
    if (en_i[2]) begin
      yb2_q  <= yb1_q;
      qy2_q  <= prod400[YbW+7:YbW];
      doy2_q <= doy2_d;
    end
    if (en_i[3]) begin
      ry3_q  <= rem400[9:0];
      qy3_q  <= qy2_q;
      doy3_q <= doy2_q;
    end
    if (en_i[4]) begin
      yoe4_q  <= yoe_wide[YoeW-1:0];
      erab4_q <= qy3_q + 8'(yr_ge);
      doy4_q  <= doy3_q;
    end
    if (en_i[5]) begin
      pday5_q    <= days_before_year(yoe4_q);
      eraprod5_q <= eraprod_d;
      kofs5_q    <= kofs_d;
      doy5_q     <= doy4_q;
    end
    if (en_i[6]) begin
      doe6_q  <= doe_d;
      base6_q <= base_d;
    end
    if (en_i[DoneStage]) begin
      offc_q[DoneStage] <= off_d[OffsetW-1:0];
      errc_q[DoneStage] <= err_d;
    end
    for (int k = DoneStage + 1; k <= NumStages; k++) begin
      if (en_i[k]) begin
        offc_q[k] <= offc_q[k-1];
        errc_q[k] <= errc_q[k-1];
      end
    end
  end

  assign offset_o = offc_q[NumStages];
  assign err_o    = errc_q[NumStages];

endmodule

// File: src/civil_date_day_number_converter.sv
// Proleptic Gregorian date converter. Action 0 adds the signed day offset of the
// input word to the epoch day number (counted from 1970-01-01) and returns year,
// month and day; action 1 turns year, month and day into a day offset from the
// epoch. Every word yields one result word. The block takes one word per clock
// when ready into twelve register stages of constant-reciprocal division and
// correction steps, then the output register. Each stage loads whenever it is
// empty or the stage after it moves, so an output stall stops only full stages
// and empty ones keep filling. The user must write the epoch register through
// cfg_we_i while no word is in flight; the block itself does not enforce it.
module civil_date_day_number_converter import cdconv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [OffsetW-1:0] cfg_wdata_i,
  cdconv_in_if.sink          in_i,
  cdconv_out_if.source       out_o
);

  logic signed [OffsetW-1:0] epoch_q;
  logic [NumStages:1]        vld_q;
  logic [NumStages:1]        act_q;
  stage_en_t                 ld;
  logic                      ld_out;

  logic                      out_valid_q;
  logic signed [YearW-1:0]   year_q;
  logic [MonthW-1:0]         month_q;
  logic [DayW-1:0]           day_q;
  logic signed [OffsetW-1:0] offset_q;
  logic                      err_q;

  logic signed [YearW-1:0]   a_year;
  logic [MonthW-1:0]         a_month;
  logic [DayW-1:0]           a_day;
  logic                      a_err;
  logic signed [OffsetW-1:0] b_offset;
  logic                      b_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= OffsetW'(EpochReset);
    end else if (cfg_we_i) begin
      epoch_q <= cfg_wdata_i;
    end
  end

  // Load enables run back from the output register through the valid bits.
  always_comb begin
    ld_out         = !out_valid_q || out_o.ready;
    ld[NumStages]  = !vld_q[NumStages] || ld_out;
    for (int k = NumStages - 1; k >= 1; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_i.ready = ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (ld_out) begin
        out_valid_q <= vld_q[NumStages];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      act_q[1] <= in_i.action;
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (ld[k]) begin
        act_q[k] <= act_q[k-1];
      end
    end
  end

  cdconv_days2date u_days2date (
    .clk_i        (clk_i),
    .en_i         (ld),
    .epoch_i      (epoch_q),
    .day_offset_i (in_i.day_offset),
    .year_o       (a_year),
    .month_o      (a_month),
    .day_o        (a_day),
    .err_o        (a_err)
  );

  cdconv_date2days u_date2days (
    .clk_i    (clk_i),
    .en_i     (ld),
    .epoch_i  (epoch_q),
    .year_i   (in_i.year_in),
    .month_i  (in_i.month_in),
    .day_i    (in_i.day_in),
    .offset_o (b_offset),
    .err_o    (b_err)
  );

  // Output register; the fields that the action does not produce read as zero.
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      if (act_q[NumStages] == ActToDate) begin
        year_q   <= a_year;
        month_q  <= a_month;
        day_q    <= a_day;
        offset_q <= '0;
        err_q    <= a_err;
      end else begin
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        offset_q <= b_offset;
        err_q    <= b_err;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.year_out    = year_q;
  assign out_o.month_out   = month_q;
  assign out_o.day_out     = day_q;
  assign out_o.offset_out  = offset_q;
  assign out_o.range_error = err_q;

  // An accepted word occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[1])
    else $error("accepted word did not enter the first stage");

  // A word waiting behind a stalled output register is held, not dropped.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && vld_q[NumStages] |=> vld_q[NumStages])
    else $error("word in the last stage lost during an output stall");

  // A date result always has a real month and a day of at least one.
  a_date_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.month_out != 4'd0 |->
      out_o.month_out <= 4'd12 && out_o.day_out != 5'd0 && out_o.offset_out == '0)
    else $error("malformed date result word");

  // A nonzero offset comes only from action 1, whose date fields are zero.
  a_offset_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.offset_out != '0 |->
      out_o.year_out == '0 && out_o.month_out == 4'd0 && out_o.day_out == 5'd0)
    else $error("offset result word carries date fields");

endmodule

// File: bench/civil_date_day_number_converter_tb.sv
// Self-checking testbench of the civil date converter: directed and random words
// are predicted in the bench and compared with every result word.
// Depends on cdconv_pkg, the channel interfaces and the converter top level.
`timescale 1ns / 100ps

module civil_date_day_number_converter_tb;
  import cdconv_pkg::*;

  localparam int     MaxWait     = 8;
  localparam int     SettleTime  = NumStages + 8;
  localparam int     CycleLimit  = 500000;
  localparam int     PhaseWords  = 390;
  localparam longint YearMin     = -(longint'(1) << (YearW - 1));
  localparam longint YearMax     = (longint'(1) << (YearW - 1)) - 1;
  localparam longint OffsetMin   = -(longint'(1) << (OffsetW - 1));
  localparam longint OffsetMax   = (longint'(1) << (OffsetW - 1)) - 1;

  typedef struct packed {
    logic signed [YearW-1:0]   year;
    logic [MonthW-1:0]         month;
    logic [DayW-1:0]           day;
    logic signed [OffsetW-1:0] offset;
    logic                      range_error;
  } conv_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [OffsetW-1:0] cfg_wdata;

  cdconv_in_if  in_if ();
  cdconv_out_if out_if ();

  civil_date_day_number_converter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  longint       cur_epoch = EpochReset;
  conv_result_t expected_words[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           idle_en = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[civil_date_day_number_converter] ERROR");
      $finish;
    end
  end

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // Predicts the result word of one input word under the current epoch.
  function automatic conv_result_t convert_word(input logic act,
                                                input logic signed [OffsetW-1:0] off_in,
                                                input logic signed [YearW-1:0] yr,
                                                input logic [MonthW-1:0] mon,
                                                input logic [DayW-1:0] dy);
    conv_result_t r;
    longint z, era, doe, yoe, doy, mp, y, m, d, off;
    r = '0;
    if (act == ActToDate) begin
      z   = cur_epoch + longint'(off_in) + DaysTo1970;
      era = floor_div(z, DaysPerEra);
      doe = z - era * DaysPerEra;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / DaysPerYear;
      doy = doe - (DaysPerYear * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      y   = yoe + era * YearsPerEra + ((m <= 2) ? 1 : 0);
      r.year        = YearW'(y);
      r.month       = MonthW'(m);
      r.day         = DayW'(d);
      r.range_error = (y < YearMin) || (y > YearMax);
    end else begin
      y = longint'(yr);
      m = longint'(mon);
      d = longint'(dy);
      // January and February belong to the March-based year before.
      if (m <= 2) y -= 1;
      era = floor_div(y, YearsPerEra);
      yoe = y - era * YearsPerEra;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * DaysPerYear + yoe / 4 - yoe / 100 + doy;
      off = era * DaysPerEra + doe - DaysTo1970 - cur_epoch;
      r.offset      = OffsetW'(off);
      r.range_error = (off < OffsetMin) || (off > OffsetMax);
    end
    return r;
  endfunction

  // Sends one word, after a random gap if idle_en, and records its predicted result.
  task automatic send_word(input logic act, input logic signed [OffsetW-1:0] off_in,
                           input logic signed [YearW-1:0] yr, input logic [MonthW-1:0] mon,
                           input logic [DayW-1:0] dy);
    int gap;
    gap = idle_en ? $urandom_range(0, MaxWait) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.action     = act;
    in_if.day_offset = off_in;
    in_if.year_in    = yr;
    in_if.month_in   = mon;
    in_if.day_in     = dy;
    do @(posedge clk_i); while (!in_if.ready);
    expected_words.push_back(convert_word(act, off_in, yr, mon, dy));
  endtask

  // Holds the input idle until every expected word has come out.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (expected_words.size() == 0);
    repeat (SettleTime) @(negedge clk_i);
  endtask

  task automatic write_epoch(input logic signed [OffsetW-1:0] value);
    drain_pipeline();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    cur_epoch = longint'(value);
  endtask

  // Result checker: the receiver stalls at random before each word if idle_en is set.
  initial begin
    int           stall;
    conv_result_t exp_word;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, MaxWait) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (expected_words.size() == 0) begin
        $error("unexpected result word");
        mismatches++;
      end else begin
        exp_word = expected_words.pop_front();
        if (out_if.year_out !== exp_word.year) begin
          $error("year_out: expected %0d, actual %0d", exp_word.year, out_if.year_out);
          mismatches++;
        end
        if (out_if.month_out !== exp_word.month) begin
          $error("month_out: expected %0d, actual %0d", exp_word.month, out_if.month_out);
          mismatches++;
        end
        if (out_if.day_out !== exp_word.day) begin
          $error("day_out: expected %0d, actual %0d", exp_word.day, out_if.day_out);
          mismatches++;
        end
        if (out_if.offset_out !== exp_word.offset) begin
          $error("offset_out: expected %0d, actual %0d", exp_word.offset, out_if.offset_out);
          mismatches++;
        end
        if (out_if.range_error !== exp_word.range_error) begin
          $error("range_error: expected %0d, actual %0d", exp_word.range_error,
                 out_if.range_error);
          mismatches++;
        end
      end
    end
  end

  // Reset epoch: plain dates, field extremes, rollover and odd month codes.
  task automatic test_reset_epoch();
    send_word(ActToDate, 25'sd0, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDate, -25'sd20454, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDate, 25'sd16777215, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDate, -25'sd16777216, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDays, 25'sd0, 16'sd2026, 4'd1, 5'd1);
    send_word(ActToDays, 25'sd0, 16'sd2000, 4'd2, 5'd29);
    send_word(ActToDays, 25'sd0, 16'sd2023, 4'd2, 5'd31);
    send_word(ActToDays, 25'sd0, -16'sd32768, 4'd1, 5'd1);
    send_word(ActToDays, 25'sd0, 16'sd32767, 4'd12, 5'd31);
    send_word(ActToDays, 25'sd0, 16'sd2024, 4'd0, 5'd15);
    send_word(ActToDays, 25'sd0, 16'sd2024, 4'd13, 5'd1);
    send_word(ActToDays, 25'sd0, 16'sd2024, 4'd15, 5'd31);
    send_word(ActToDays, 25'sd0, 16'sd2024, 4'd3, 5'd0);
  endtask

  // Epoch at both extremes, where the results leave their field ranges.
  task automatic test_epoch_extremes();
    write_epoch(25'sd16777215);
    send_word(ActToDays, 25'sd0, -16'sd32768, 4'd1, 5'd1);
    send_word(ActToDate, 25'sd16777215, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDate, -25'sd16777216, 16'sd0, 4'd0, 5'd0);
    write_epoch(-25'sd16777216);
    send_word(ActToDays, 25'sd0, 16'sd32767, 4'd12, 5'd31);
    send_word(ActToDate, -25'sd16777216, 16'sd0, 4'd0, 5'd0);
    send_word(ActToDate, 25'sd16777215, 16'sd0, 4'd0, 5'd0);
  endtask

  // Random words under several epochs; one phase runs without any idling.
  task automatic test_random_words();
    logic signed [OffsetW-1:0] epoch_val, off_in;
    logic signed [YearW-1:0]   yr;
    logic [MonthW-1:0]         mon;
    logic [DayW-1:0]           dy;
    logic                      act;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       epoch_val = 25'sd0;
        1:       epoch_val = OffsetW'(EpochReset);
        2:       epoch_val = -25'sd16777216;
        3:       epoch_val = 25'sd16777215;
        default: epoch_val = OffsetW'($urandom());
      endcase
      write_epoch(epoch_val);
      idle_en = (phase != 1);
      for (int n = 0; n < PhaseWords; n++) begin
        act = 1'($urandom());
        case ($urandom_range(0, 2))
          0:       off_in = OffsetW'($urandom());
          1:       off_in = OffsetW'(int'($urandom_range(0, 200000)) - 100000);
          default: off_in = OffsetW'(int'($urandom_range(0, 2000000)) - 1000000);
        endcase
        if ($urandom_range(0, 1) == 0) yr = YearW'($urandom());
        else yr = YearW'(int'($urandom_range(1500, 2500)));
        if ($urandom_range(0, 7) == 0) mon = MonthW'($urandom());
        else mon = MonthW'($urandom_range(1, 12));
        dy = DayW'($urandom());
        send_word(act, off_in, yr, mon, dy);
        // Let the pipeline run dry once in the middle of a phase.
        if (phase == 4 && n == PhaseWords / 2) drain_pipeline();
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.action     = ActToDate;
    in_if.day_offset = '0;
    in_if.year_in    = '0;
    in_if.month_in   = '0;
    in_if.day_in     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_epoch();
    test_epoch_extremes();
    test_random_words();
    drain_pipeline();

    if (mismatches == 0) begin
      $display("[civil_date_day_number_converter] OK");
    end else begin
      $display("[civil_date_day_number_converter] ERROR");
    end
    $finish;
  end

endmodule
